// ===== rtl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and codes of the Go-Back-N ARQ window block: register map,
// configuration bundle, result kinds and frame outcomes.
// ----------------------------------------------------------------------------
package gbn_pkg;

	// APB address width: three 32-bit registers at 0x0, 0x4, 0x8
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_FRAME_TOTAL = 2'd0;
	localparam logic [1:0] REG_WIN_LIMIT   = 2'd1;
	localparam logic [1:0] REG_TMO_LIMIT   = 2'd2;

	// register reset values
	localparam logic [15:0] FRAME_TOTAL_RST = 16'd5;
	localparam logic [3:0]  WIN_LIMIT_RST   = 4'd2;
	localparam logic [7:0]  TMO_LIMIT_RST   = 8'd3;

	// result kinds
	localparam logic KIND_FRAME   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// frame outcomes
	localparam logic [1:0] OC_ACCEPT  = 2'd0;
	localparam logic [1:0] OC_DISCARD = 2'd1;
	localparam logic [1:0] OC_LOST    = 2'd2;

	// configuration bundle from the register file to the core
	typedef struct packed {
		logic [15:0] frame_total;
		logic [3:0]  win_limit;
		logic [7:0]  tmo_limit;
	} cfg_t;

endpackage

// ===== rtl/gbn_cfg.sv =====
// ----------------------------------------------------------------------------
// gbn_cfg
// APB register file holding the frame total, window limit and timeout limit.
// Writes complete in the access phase; reads return the register value.
// ----------------------------------------------------------------------------
module gbn_cfg
	import gbn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	// write the addressed register, ignore unmapped slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_total <= FRAME_TOTAL_RST;
			cfg_q.win_limit   <= WIN_LIMIT_RST;
			cfg_q.tmo_limit   <= TMO_LIMIT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FRAME_TOTAL: cfg_q.frame_total <= pwdata[15:0];
				REG_WIN_LIMIT:   cfg_q.win_limit   <= pwdata[3:0];
				REG_TMO_LIMIT:   cfg_q.tmo_limit   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_FRAME_TOTAL: prdata = {16'd0, cfg_q.frame_total};
			REG_WIN_LIMIT:   prdata = {28'd0, cfg_q.win_limit};
			REG_TMO_LIMIT:   prdata = {24'd0, cfg_q.tmo_limit};
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/gbn_core.sv =====
// ----------------------------------------------------------------------------
// gbn_core
// Tick sequencer: sends one frame per cycle through the shared compare and
// increment step, slides the window, runs the timer, then emits one result
// per frame sent plus a closing summary through an output register.
// ----------------------------------------------------------------------------
module gbn_core
	import gbn_pkg::*;
#(
	parameter int unsigned MAX_WINDOW = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  deliver_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [15:0] frame_seq,
	output logic [1:0]  outcome,
	output logic [15:0] window_base,
	output logic [15:0] next_to_send,
	output logic        timed_out,
	output logic        all_done,
	output logic        last
);

	localparam int unsigned CNT_W    = $clog2(MAX_WINDOW + 1);
	localparam int unsigned IDX_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int unsigned OC_DEPTH = 1 << IDX_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SEND = 5'b00010,
		ST_ACK  = 5'b00100,
		ST_TMR  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t           state_q;
	logic [15:0]      base_q;
	logic [15:0]      send_q;
	logic [15:0]      exp_q;
	logic             trun_q;
	logic [7:0]       tcnt_q;
	logic [15:0]      start_q;
	logic [CNT_W-1:0] nsent_q;
	logic [CNT_W-1:0] emit_q;
	logic [7:0]       mask_q;
	logic             tout_q;
	logic [1:0]       oc_q [OC_DEPTH];

	logic             out_valid_q;
	logic             kind_q;
	logic [15:0]      frame_seq_q;
	logic [1:0]       outcome_q;
	logic [15:0]      base_out_q;
	logic [15:0]      send_out_q;
	logic             tout_out_q;
	logic             done_out_q;
	logic             last_q;

	logic [CNT_W-1:0] win;
	logic             can_send;
	logic [1:0]       oc_new;
	logic             ack_slide;
	logic [15:0]      base_new;
	logic [7:0]       tinc;
	logic             load_out;
	logic             summ;
	logic             accept;

	// clamp the window to one..MAX_WINDOW
	always_comb begin
		if (cfg.win_limit == 4'd0) begin
			win = CNT_W'(1);
		end else if (32'(cfg.win_limit) > MAX_WINDOW) begin
			win = CNT_W'(MAX_WINDOW);
		end else begin
			win = CNT_W'(cfg.win_limit);
		end
	end

	// shared send step: window, total and base+window checks, outcome
	assign can_send = (nsent_q < win) && (send_q < cfg.frame_total) &&
		({1'b0, send_q} < ({1'b0, base_q} + 17'(win)));

	always_comb begin
		if (!mask_q[0]) begin
			oc_new = OC_LOST;
		end else if (send_q == exp_q) begin
			oc_new = OC_ACCEPT;
		end else begin
			oc_new = OC_DISCARD;
		end
	end

	// cumulative ACK and timer step
	assign ack_slide = (base_q < cfg.frame_total) && (base_q < exp_q);
	assign base_new  = (exp_q < cfg.frame_total) ? exp_q : cfg.frame_total;
	assign tinc      = tcnt_q + 8'd1;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign summ     = (emit_q == nsent_q);

	// sequencer and protocol state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			send_q      <= '0;
			exp_q       <= '0;
			trun_q      <= 1'b0;
			tcnt_q      <= '0;
			start_q     <= '0;
			nsent_q     <= '0;
			emit_q      <= '0;
			mask_q      <= '0;
			tout_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mask_q  <= deliver_mask;
						nsent_q <= '0;
						start_q <= send_q;
						tout_q  <= 1'b0;
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (can_send) begin
						if (oc_new == OC_ACCEPT) begin
							exp_q <= exp_q + 16'd1;
						end
						if (!trun_q) begin
							trun_q <= 1'b1;
							tcnt_q <= '0;
						end
						send_q  <= send_q + 16'd1;
						mask_q  <= {1'b0, mask_q[7:1]};
						nsent_q <= nsent_q + CNT_W'(1);
					end else begin
						state_q <= ST_ACK;
					end
				end
				ST_ACK: begin
					if (ack_slide) begin
						base_q <= base_new;
						trun_q <= (base_new != send_q);
						tcnt_q <= '0;
					end
					state_q <= ST_TMR;
				end
				ST_TMR: begin
					if (trun_q) begin
						if (tinc >= cfg.tmo_limit) begin
							tout_q <= 1'b1;
							send_q <= base_q;
							tcnt_q <= '0;
						end else begin
							tcnt_q <= tinc;
						end
					end
					emit_q  <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load_out) begin
						if (summ) begin
							state_q <= ST_IDLE;
						end else begin
							emit_q <= emit_q + CNT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// record each frame's outcome
	always_ff @(posedge clk) begin
		if (state_q == ST_SEND && can_send) begin
			oc_q[nsent_q[IDX_W-1:0]] <= oc_new;
		end
	end

	// load the output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_q      <= summ ? KIND_SUMMARY : KIND_FRAME;
			frame_seq_q <= summ ? 16'd0 : (start_q + 16'(emit_q));
			outcome_q   <= summ ? OC_ACCEPT : oc_q[emit_q[IDX_W-1:0]];
			base_out_q  <= base_q;
			send_out_q  <= send_q;
			tout_out_q  <= tout_q;
			done_out_q  <= (base_q >= cfg.frame_total);
			last_q      <= summ;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign frame_seq    = frame_seq_q;
	assign outcome      = outcome_q;
	assign window_base  = base_out_q;
	assign next_to_send = send_out_q;
	assign timed_out    = tout_out_q;
	assign all_done     = done_out_q;
	assign last         = last_q;

endmodule

// ===== rtl/go_back_n_arq_window_top.sv =====
// Timing: an accepted item holds in_stall high through the send, ack, timer and emit
// states; in emit, results are loaded one per cycle while the output is not stalled.
// The next item is taken only once the summary of the last one is loaded, so items do
// not overlap; the send step moves one frame per cycle, and output stall holds emit.
// Reset: arst_n clears sequence numbers, timer and output valid, and loads the
// registers with frame total 5, window limit 2, timeout limit 3.
// ----------------------------------------------------------------------------
// go_back_n_arq_window_top
// Go-Back-N sender with an in-order receiver, advanced one tick per item, with
// an APB register port for the transfer length, window and timeout.
// ----------------------------------------------------------------------------
module go_back_n_arq_window_top
	import gbn_pkg::*;
#(
	parameter int unsigned MAX_WINDOW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         deliver_mask,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic [15:0]        frame_seq,
	output logic [1:0]         outcome,
	output logic [15:0]        window_base,
	output logic [15:0]        next_to_send,
	output logic               timed_out,
	output logic               all_done,
	output logic               last
);

	cfg_t cfg;

	gbn_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gbn_core #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.deliver_mask (deliver_mask),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.frame_seq    (frame_seq),
		.outcome      (outcome),
		.window_base  (window_base),
		.next_to_send (next_to_send),
		.timed_out    (timed_out),
		.all_done     (all_done),
		.last         (last)
	);

	// an accepted item raises in_stall and blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after item accept");

	// the closing result is always a summary
	a_last_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> kind == KIND_SUMMARY)
		else $error("last result is not a summary");

	// frame reports carry a defined outcome; summaries carry accept and frame_seq zero
	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_FRAME && outcome <= OC_LOST) ||
			(kind == KIND_SUMMARY && outcome == OC_ACCEPT && frame_seq == 16'd0))
		else $error("bad outcome code on result");

endmodule

// ===== verif/gbn_checker.sv =====
// ----------------------------------------------------------------------------
// gbn_checker
// Watches the register port and both item channels of the Go-Back-N window
// block, predicts every frame report and tick summary, and compares them in
// order against what the block returns.
// ----------------------------------------------------------------------------
module gbn_checker
	import gbn_pkg::*;
#(
	parameter int unsigned MAX_WINDOW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [7:0]         deliver_mask,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               kind,
	input  logic [15:0]        frame_seq,
	input  logic [1:0]         outcome,
	input  logic [15:0]        window_base,
	input  logic [15:0]        next_to_send,
	input  logic               timed_out,
	input  logic               all_done,
	input  logic               last,
	output int                 fail_count,
	output int                 pending,
	output int                 checked_count,
	output logic [15:0]        pred_base
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        kind;
		logic [15:0] frame_seq;
		logic [1:0]  outcome;
		logic [15:0] window_base;
		logic [15:0] next_to_send;
		logic        timed_out;
		logic        all_done;
		logic        last;
	} gbn_report_t;

	// shadow configuration and protocol state
	cfg_t        cfg;
	int unsigned base_q;
	int unsigned send_q;
	int unsigned rx_expect;
	bit          timer_on;
	logic [7:0]  timer_cnt;

	gbn_report_t pending_reports[$];

	// advance the sender and receiver by one tick and queue its reports
	function automatic void run_tick(input logic [7:0] mask);
		int unsigned win;
		int unsigned nsent;
		int unsigned k;
		logic [15:0] sent_seq[MAX_WINDOW];
		logic [1:0]  sent_oc[MAX_WINDOW];
		logic [1:0]  oc;
		bit          tout;
		gbn_report_t r;
		win = cfg.win_limit;
		if (win > MAX_WINDOW) win = MAX_WINDOW;
		if (win == 0) win = 1;
		nsent = 0;
		tout = 1'b0;

		// send every new frame that fits the window
		while (nsent < win && send_q < cfg.frame_total && send_q < base_q + win) begin
			if (nsent >= 8 || !mask[nsent]) begin
				oc = OC_LOST;
			end else if (send_q == rx_expect) begin
				oc = OC_ACCEPT;
				rx_expect = (rx_expect + 1) & 16'hFFFF;
			end else begin
				oc = OC_DISCARD;
			end
			sent_seq[nsent] = send_q[15:0];
			sent_oc[nsent] = oc;
			nsent++;
			if (!timer_on) begin
				timer_on = 1'b1;
				timer_cnt = 8'd0;
			end
			send_q = (send_q + 1) & 16'hFFFF;
		end

		// slide the base on the cumulative ack
		if (base_q < cfg.frame_total && base_q < rx_expect) begin
			base_q = (rx_expect < cfg.frame_total) ? rx_expect : cfg.frame_total;
			timer_on = (base_q != send_q);
			timer_cnt = 8'd0;
		end

		// count the timer, go back to the base on expiry
		if (timer_on) begin
			timer_cnt = timer_cnt + 8'd1;
			if (timer_cnt >= cfg.tmo_limit) begin
				tout = 1'b1;
				send_q = base_q;
				timer_cnt = 8'd0;
			end
		end

		for (k = 0; k <= nsent; k++) begin
			r.kind         = (k == nsent) ? KIND_SUMMARY : KIND_FRAME;
			r.frame_seq    = (k == nsent) ? 16'd0 : sent_seq[k];
			r.outcome      = (k == nsent) ? OC_ACCEPT : sent_oc[k];
			r.window_base  = base_q[15:0];
			r.next_to_send = send_q[15:0];
			r.timed_out    = tout;
			r.all_done     = (base_q >= cfg.frame_total);
			r.last         = (k == nsent);
			pending_reports.push_back(r);
		end
	endfunction

	// compare one returned item with the oldest prediction
	function automatic void check_report();
		gbn_report_t e;
		if (pending_reports.size() == 0) begin
			$error("unexpected result: kind %0d frame_seq %0d", kind, frame_seq);
			fail_count++;
			return;
		end
		e = pending_reports.pop_front();
		checked_count++;
		if (kind !== e.kind) begin
			$error("kind: expected %0d, actual %0d", e.kind, kind);
			fail_count++;
		end
		if (frame_seq !== e.frame_seq) begin
			$error("frame_seq: expected %0d, actual %0d", e.frame_seq, frame_seq);
			fail_count++;
		end
		if (outcome !== e.outcome) begin
			$error("outcome: expected %0d, actual %0d", e.outcome, outcome);
			fail_count++;
		end
		if (window_base !== e.window_base) begin
			$error("window_base: expected %0d, actual %0d", e.window_base, window_base);
			fail_count++;
		end
		if (next_to_send !== e.next_to_send) begin
			$error("next_to_send: expected %0d, actual %0d", e.next_to_send, next_to_send);
			fail_count++;
		end
		if (timed_out !== e.timed_out) begin
			$error("timed_out: expected %0d, actual %0d", e.timed_out, timed_out);
			fail_count++;
		end
		if (all_done !== e.all_done) begin
			$error("all_done: expected %0d, actual %0d", e.all_done, all_done);
			fail_count++;
		end
		if (last !== e.last) begin
			$error("last: expected %0d, actual %0d", e.last, last);
			fail_count++;
		end
	endfunction

	// sample both channels and the register port at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.frame_total = FRAME_TOTAL_RST;
			cfg.win_limit   = WIN_LIMIT_RST;
			cfg.tmo_limit   = TMO_LIMIT_RST;
			base_q = 0;
			send_q = 0;
			rx_expect = 0;
			timer_on = 1'b0;
			timer_cnt = 8'd0;
			pending_reports.delete();
			fail_count = 0;
			checked_count = 0;
		end else begin
			if (out_valid && !out_stall) check_report();
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_FRAME_TOTAL: cfg.frame_total = pwdata[15:0];
					REG_WIN_LIMIT:   cfg.win_limit   = pwdata[3:0];
					REG_TMO_LIMIT:   cfg.tmo_limit   = pwdata[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) run_tick(deliver_mask);
		end
		pending = pending_reports.size();
		pred_base = base_q[15:0];
	end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Go-Back-N window block: directed ticks over the
// register extremes, then random phases of delivery masks with random gaps
// on both channels and one long receiver hold-off; checking is in gbn_checker.
// ----------------------------------------------------------------------------
module tb
	import gbn_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_WIN = 8;
	localparam logic [1:0]  REG_UNUSED = 2'd3;
	localparam int          LIMIT_CYCLES = 600000;
	localparam int          HOLD_CYCLES = 400;
	localparam int          RANDOM_PHASES = 8;
	localparam int          TICKS_PER_PHASE = 25;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         deliver_mask;
	logic               out_valid;
	logic               out_stall;
	logic               kind;
	logic [15:0]        frame_seq;
	logic [1:0]         outcome;
	logic [15:0]        window_base;
	logic [15:0]        next_to_send;
	logic               timed_out;
	logic               all_done;
	logic               last;

	int          fail_count;
	int          pending;
	int          checked_count;
	logic [15:0] pred_base;

	int ticks_sent = 0;
	int settings_used = 0;
	bit no_gaps = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	always #4 clk = ~clk;

	go_back_n_arq_window_top #(.MAX_WINDOW(MAX_WIN)) i_dut (.*);

	gbn_checker #(.MAX_WINDOW(MAX_WIN)) i_chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .deliver_mask(deliver_mask),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.frame_seq(frame_seq), .outcome(outcome), .window_base(window_base),
		.next_to_send(next_to_send), .timed_out(timed_out), .all_done(all_done),
		.last(last),
		.fail_count(fail_count), .pending(pending), .checked_count(checked_count),
		.pred_base(pred_base)
	);

	// mostly short gaps, a few long ones; none while the receiver holds off
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || (hold_req && !hold_done)) return 0;
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// clean channel most often, single losses, random noise, or every frame lost
	function automatic logic [7:0] pick_mask();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 8'hFF;
		if (r < 75) return 8'hFF & ~(8'h01 << $urandom_range(0, 7));
		if (r < 92) return 8'($urandom());
		return 8'h00;
	endfunction

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// drain the block, then load a new register setting
	task automatic set_phase(input logic [15:0] tot, input logic [3:0] win,
			input logic [7:0] tmo);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		apb_write(REG_FRAME_TOTAL, {16'($urandom()), tot});
		apb_write(REG_WIN_LIMIT, {28'($urandom()), win});
		apb_write(REG_TMO_LIMIT, {24'($urandom()), tmo});
		settings_used++;
	endtask

	// offer one tick and hold it until accepted
	task automatic send_tick(input logic [7:0] m);
		int gap;
		in_valid <= 1'b1;
		deliver_mask <= m;
		do @(posedge clk); while (in_stall);
		ticks_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// receiver: random ready and stall stretches, one long hold-off on request
	initial begin
		int len;
		out_stall <= 1'b0;
		forever begin
			out_stall <= 1'b0;
			repeat ((no_gaps ? 20 : $urandom_range(1, 12))) @(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				len = no_gaps ? 0 : pick_gap();
				if (len > 0) begin
					out_stall <= 1'b1;
					repeat (len) @(posedge clk);
				end
			end
		end
	end

	// give up on a hung run
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$error("run did not drain within %0d cycles", LIMIT_CYCLES);
		$display("FAIL");
		$finish;
	end

	initial begin
		int p;
		int k;
		int tot;
		int r;
		logic [3:0] win;
		logic [7:0] tmo;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		deliver_mask <= 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: send to the frame total through a loss and a discard, then time out and go back
		send_tick(8'hFF);
		send_tick(8'h01);
		send_tick(8'hFF);
		send_tick(8'hFF);
		send_tick(8'h00);

		// window above the maximum saturates; stray write to an unused index
		set_phase(16'd12, 4'd15, 8'd1);
		apb_write(REG_UNUSED, 32'hFFFF_FFFF);
		send_tick(8'hFE);
		send_tick(8'h00);
		send_tick(8'hFF);
		send_tick(8'h55);
		send_tick(8'hAA);
		send_tick(8'hFF);

		// zero window acts as one, zero timeout expires at once
		set_phase(16'd20, 4'd0, 8'd0);
		send_tick(8'h01);
		send_tick(8'h00);
		send_tick(8'h01);
		send_tick(8'hFF);
		send_tick(8'hFE);

		// longest transfer and timeout with a full window
		set_phase(16'd65535, 4'd8, 8'd255);
		send_tick(8'h00);
		send_tick(8'hFF);
		send_tick(8'h0F);
		send_tick(8'hF0);

		// shrink the transfer below progress: finished, summaries only
		set_phase(16'd1, 4'd8, 8'd2);
		send_tick(8'hFF);
		send_tick(8'h00);

		// random phases, most extending the transfer past the current base
		for (p = 0; p < RANDOM_PHASES; p++) begin
			r = $urandom_range(0, 9);
			tot = (r < 8) ? int'(pred_base) + $urandom_range(4, 48) : $urandom_range(1, 65535);
			if (tot > 65535) tot = 65535;
			case ($urandom_range(0, 9))
				0: win = 4'd0;
				1: win = 4'($urandom_range(9, 15));
				default: win = 4'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 9))
				0: tmo = 8'd0;
				1: tmo = 8'd255;
				2: tmo = 8'($urandom_range(7, 20));
				default: tmo = 8'($urandom_range(1, 6));
			endcase
			set_phase(16'(tot), win, tmo);
			no_gaps = (p == 2);
			hold_req = (p == 4);
			for (k = 0; k < TICKS_PER_PHASE; k++) send_tick(pick_mask());
			no_gaps = 1'b0;
		end

		// drain and let the block settle
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("Covered %0d ticks over %0d register settings, %0d reports checked.",
			ticks_sent, settings_used, checked_count);
		$display("Included saturated and zero windows, zero timeout, %s %0d-cycle hold-off.",
			"finished transfers,", HOLD_CYCLES);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/gbn_pkg.sv
rtl/gbn_cfg.sv
rtl/gbn_core.sv
rtl/go_back_n_arq_window_top.sv
verif/gbn_checker.sv
verif/tb.sv
